[rtl/plct_pkg.sv]
// ----------------------------------------------------------------------------
// plct_pkg
// Types and constants shared by the piecewise-linear calibration table.
// ----------------------------------------------------------------------------
package plct_pkg;

  localparam int PointsPerTable = 32;
  localparam int AmpFracBits    = 10;
  localparam int IdxW           = $clog2(PointsPerTable);
  localparam int CntW           = $clog2(PointsPerTable + 1);
  localparam int AddrW          = IdxW + 1;
  localparam int AmpW           = 24;
  localparam int ValW           = 32;
  // largest difference still counted as a match: d * 1000 < 2^frac
  localparam int TolMax         = ((1 << AmpFracBits) - 1) / 1000;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_SET    = 2'd1,
    MODE_APPEND = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UPDATED    = 3'd1,
    ST_NO_BRACKET = 3'd2,
    ST_REJECTED   = 3'd3,
    ST_FULL       = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic                   table_select;
    logic [AmpW-1:0]        amplitude;
    logic signed [ValW-1:0] point_value;
  } req_t;

  typedef struct packed {
    logic signed [ValW-1:0] result_value;
    logic [2:0]             status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_LAST, S_CHK_LAST, S_SCAN_RD, S_SCAN_CHK, S_INTERP, S_DIV_WAIT,
    S_SHIFT_RD, S_SHIFT_WR, S_INSERT, S_DONE
  } state_t;

endpackage

[rtl/plct_divider.sv]
// ----------------------------------------------------------------------------
// plct_divider
// Signed restoring divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module plct_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [24:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  import plct_pkg::*;

  logic [63:0] num;
  logic [63:0] quo;
  logic [25:0] rem;
  logic [24:0] den;
  logic        neg;
  logic [6:0]  cnt;
  logic [25:0] trial;

  assign trial = {rem[24:0], num[63]} - {1'b0, den};

  // one bit of the magnitude per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
      neg  <= dividend[63];
      num  <= dividend[63] ? (~dividend + 64'd1) : dividend;
      den  <= divisor;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      num <= {num[62:0], 1'b0};
      if (!trial[25]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[24:0], num[63]};
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  assign quotient = neg ? (~quo + 64'd1) : quo;

endmodule

[rtl/piecewise_linear_calibration_table.sv]
// Lookup reads and checks the points in turn, then interpolates, divides and
// responds, or responds without interpolating when there is no bracket. Set
// reads the last point, scans, shifts later points up to insert, and writes;
// append writes directly, or only responds when full. Throughput: one request
// at a time, the next one is taken the cycle after the response leaves.
// Reset clears both point counts and control state; point memory is not cleared.
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_table
// Two (amplitude, value) tables with interpolated lookup, insert and append.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  plct_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output plct_pkg::rsp_t out_data
);
  import plct_pkg::*;

  // point memory, amplitude and value side by side
  logic [AmpW+ValW-1:0] mem [2*PointsPerTable];
  logic [AmpW+ValW-1:0] rd_q;
  logic [AddrW-1:0]     rd_addr;
  logic                 rd_en;
  logic [AddrW-1:0]     wr_addr;
  logic [AmpW+ValW-1:0] wr_data;
  logic                 wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  logic [AmpW-1:0]        q_amp;
  logic signed [ValW-1:0] q_val;
  assign q_amp = rd_q[AmpW+ValW-1:ValW];
  assign q_val = rd_q[ValW-1:0];

  state_t state, state_next;
  req_t   req;
  logic [CntW-1:0] cnt [2];
  logic [CntW-1:0] n;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] pos;
  logic            have_lo;
  logic [AmpW-1:0]        lo_amp;
  logic signed [ValW-1:0] lo_val;
  logic [AmpW-1:0]        hi_amp;
  logic [AmpW-1:0]        wr_amp;
  logic signed [63:0]     prod;
  rsp_t                   rsp;

  logic        div_start, div_busy;
  logic [63:0] div_q;

  plct_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(prod), .divisor({1'b0, hi_amp - lo_amp}),
    .busy(div_busy), .quotient(div_q)
  );

  logic [CntW-1:0] in_cnt;
  logic            in_full;
  logic            last_scan;

  assign n         = cnt[req.table_select];
  assign in_cnt    = cnt[in_data.table_select];
  assign in_full   = in_cnt == CntW'(PointsPerTable);
  assign last_scan = (idx + CntW'(1)) >= n;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign out_data  = rsp;

  logic [AmpW-1:0] diff;
  logic            match;
  assign diff  = (q_amp > req.amplitude) ? q_amp - req.amplitude : req.amplitude - q_amp;
  assign match = diff <= AmpW'(TolMax);

  // interpolation numerator (y1 - y0) * (a - x0)
  logic signed [ValW:0]        dy;
  logic signed [AmpW:0]        da;
  logic signed [ValW+AmpW+1:0] mul;
  assign dy  = $signed({q_val[ValW-1], q_val}) - $signed({lo_val[ValW-1], lo_val});
  assign da  = $signed({1'b0, req.amplitude}) - $signed({1'b0, lo_amp});
  assign mul = dy * da;

  function automatic logic [AddrW-1:0] addr(input logic t, input logic [CntW-1:0] i);
    return {t, i[IdxW-1:0]};
  endfunction

  // sequencer: next state, memory controls and divider start
  always_comb begin
    state_next = state;
    rd_en = 1'b0; rd_addr = addr(req.table_select, idx);
    wr_en = 1'b0; wr_addr = addr(req.table_select, idx);
    wr_data = {wr_amp, req.point_value};
    div_start = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        unique case (mode_t'(in_data.mode))
          MODE_LOOKUP: state_next = (in_cnt == '0) ? S_DONE : S_SCAN_RD;
          MODE_SET:    state_next = (in_cnt == '0) ? S_DONE : S_RD_LAST;
          MODE_APPEND: state_next = in_full ? S_DONE : S_INSERT;
          default:     state_next = S_DONE;
        endcase
      end
      S_RD_LAST: begin
        rd_en = 1'b1; rd_addr = addr(req.table_select, n - CntW'(1));
        state_next = S_CHK_LAST;
      end
      // table 0 refuses a value above the last point's value
      S_CHK_LAST:
        state_next = (!req.table_select && req.point_value > q_val) ? S_DONE : S_SCAN_RD;
      S_SCAN_RD: begin
        rd_en = 1'b1; state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (mode_t'(req.mode) == MODE_LOOKUP) begin
          if (q_amp <= req.amplitude) state_next = last_scan ? S_DONE : S_SCAN_RD;
          else state_next = have_lo ? S_INTERP : S_DONE;
        end else begin
          if (idx == '0 && q_amp > req.amplitude) state_next = S_DONE;
          else if (match) state_next = S_INSERT;
          else if (q_amp > req.amplitude)
            state_next = (n == CntW'(PointsPerTable)) ? S_DONE : S_SHIFT_RD;
          else state_next = last_scan ? S_DONE : S_SCAN_RD;
        end
      end
      S_INTERP: begin
        div_start = 1'b1; state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (!div_busy) state_next = S_DONE;
      S_SHIFT_RD: begin
        rd_en = 1'b1; rd_addr = addr(req.table_select, idx - CntW'(1));
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1; wr_data = rd_q;
        state_next = ((idx - CntW'(1)) == pos) ? S_INSERT : S_SHIFT_RD;
      end
      S_INSERT: begin
        wr_en = 1'b1; state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
    end else begin
      state <= state_next;
      // response handshake
      if (state == S_DONE) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          req <= in_data;
          idx <= (mode_t'(in_data.mode) == MODE_APPEND) ? in_cnt : '0;
          have_lo <= 1'b0;
          wr_amp <= in_data.amplitude;
          rsp.result_value <= '0;
          rsp.status <= (mode_t'(in_data.mode) == MODE_LOOKUP) ? ST_NO_BRACKET :
                        (mode_t'(in_data.mode) == MODE_APPEND) ?
                        (in_full ? ST_FULL : ST_OK) : ST_REJECTED;
        end
        S_SCAN_CHK: begin
          if (mode_t'(req.mode) == MODE_LOOKUP) begin
            if (q_amp <= req.amplitude) begin
              have_lo <= 1'b1; lo_amp <= q_amp; lo_val <= q_val;
              if (!last_scan) idx <= idx + CntW'(1);
            end else begin
              hi_amp <= q_amp;
              prod <= 64'(mul);
            end
          end else if (!(idx == '0 && q_amp > req.amplitude)) begin
            // update keeps the stored amplitude
            if (match) begin
              rsp.status <= ST_UPDATED;
              wr_amp <= q_amp;
            end else if (q_amp > req.amplitude) begin
              if (n == CntW'(PointsPerTable)) rsp.status <= ST_FULL;
              else begin
                rsp.status <= ST_OK;
                pos <= idx;
                idx <= n;
              end
            end else if (!last_scan) idx <= idx + CntW'(1);
          end
        end
        S_DIV_WAIT: if (!div_busy) begin
          rsp.result_value <= ValW'(div_q) + lo_val;
          rsp.status <= ST_OK;
        end
        S_SHIFT_WR: idx <= idx - CntW'(1);
        S_INSERT: if (rsp.status == ST_OK) cnt[req.table_select] <= n + CntW'(1);
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= CntW'(PointsPerTable) && cnt[1] <= CntW'(PointsPerTable))
    else $error("point count beyond table size");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_IDLE)
    else $error("response pending while busy");
  a_no_wr_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !wr_en)
    else $error("memory write while idle");
`endif

endmodule

[bench/piecewise_linear_calibration_table_test.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_table_test
// Drives lookup, set, append and unused-mode requests into both calibration tables with
// random idling on both sides, predicts every response from a local copy
// of the tables, and compares the responses field by field in order.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration_table_test;
  import plct_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  piecewise_linear_calibration_table uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the tables
  logic [AmpW-1:0]        cal_amp [2][PointsPerTable];
  logic signed [ValW-1:0] cal_val [2][PointsPerTable];
  int                     cal_cnt [2];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   stim_done = 1'b0;
  bit   quiet = 1'b0;
  int   drv_gap = 0;
  int   mon_gap = 0;

  // append a request to the pending queue
  task automatic queue_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic bit amp_close(logic [AmpW-1:0] x, logic [AmpW-1:0] a);
    longint d;
    d = (x > a) ? longint'(x - a) : longint'(a - x);
    return d * 1000 < (longint'(1) << AmpFracBits);
  endfunction

  // compute the response and update the local tables
  function automatic rsp_t calibrate(req_t r);
    rsp_t   o;
    int     t, n, i, lo, hi;
    bit     have_lo, have_hi, done;
    longint dy, da, dx;
    o = '0;
    t = int'(r.table_select);
    n = cal_cnt[t];
    case (mode_t'(r.mode))
      MODE_LOOKUP: begin
        have_lo = 0; have_hi = 0; lo = 0; hi = 0;
        for (i = 0; i < n && !have_hi; i++) begin
          if (cal_amp[t][i] <= r.amplitude) begin
            lo = i; have_lo = 1;
          end else begin
            hi = i; have_hi = 1;
          end
        end
        if (!have_lo || !have_hi) o.status = ST_NO_BRACKET;
        else begin
          dy = longint'(cal_val[t][hi]) - longint'(cal_val[t][lo]);
          da = longint'(r.amplitude) - longint'(cal_amp[t][lo]);
          dx = longint'(cal_amp[t][hi]) - longint'(cal_amp[t][lo]);
          o.result_value = 32'((dy * da) / dx + longint'(cal_val[t][lo]));
          o.status = ST_OK;
        end
      end
      MODE_SET: begin
        if (n == 0 || r.amplitude < cal_amp[t][0] ||
            (t == 0 && r.point_value > cal_val[t][n-1])) o.status = ST_REJECTED;
        else begin
          done = 0;
          for (i = 0; i < n; i++) begin
            if (amp_close(cal_amp[t][i], r.amplitude)) begin
              cal_val[t][i] = r.point_value;
              o.status = ST_UPDATED;
              done = 1;
              break;
            end
            if (cal_amp[t][i] > r.amplitude) break;
          end
          if (!done) begin
            if (i >= n) o.status = ST_REJECTED;
            else if (n >= PointsPerTable) o.status = ST_FULL;
            else begin
              for (int k = n; k > i; k--) begin
                cal_amp[t][k] = cal_amp[t][k-1];
                cal_val[t][k] = cal_val[t][k-1];
              end
              cal_amp[t][i] = r.amplitude;
              cal_val[t][i] = r.point_value;
              cal_cnt[t] = n + 1;
              o.status = ST_OK;
            end
          end
        end
      end
      MODE_APPEND: begin
        if (n >= PointsPerTable) o.status = ST_FULL;
        else begin
          cal_amp[t][n] = r.amplitude;
          cal_val[t][n] = r.point_value;
          cal_cnt[t] = n + 1;
          o.status = ST_OK;
        end
      end
      default: o.status = ST_REJECTED;
    endcase
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic req_t mk(mode_t m, bit t, logic [AmpW-1:0] a, int v);
    req_t r;
    r.mode = m; r.table_select = t; r.amplitude = a; r.point_value = v;
    return r;
  endfunction

  // ascending run of appended points with random amplitude steps
  task automatic add_burst(bit t);
    logic [AmpW-1:0] a;
    int              npts, v;
    npts = $urandom_range(2, 12);
    a = 24'($urandom_range(0, 4000));
    v = $urandom;
    for (int k = 0; k < npts; k++) begin
      queue_req(mk(MODE_APPEND, t, a, v));
      a = 24'(a + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3)
                                              : $urandom_range(2, 5000)));
      v = v - $urandom_range(0, 1 << 20);
    end
  endtask

  function automatic req_t rand_req();
    req_t r;
    int   p;
    r = '0;
    r.table_select = 1'($urandom_range(0, 1));
    r.point_value = $urandom;
    r.amplitude = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 70000));
    p = $urandom_range(0, 99);
    if (p < 45) r.mode = MODE_LOOKUP;
    else if (p < 85) r.mode = MODE_SET;
    else if (p < 97) r.mode = MODE_APPEND;
    else r.mode = MODE_UNUSED;
    // table 0 sets need small values to pass the last-value rule
    if (r.mode == MODE_SET && $urandom_range(0, 1)) r.point_value = -int'($urandom_range(0, 1 << 30)) - (1 << 30);
    return r;
  endfunction

  // stimulus
  initial begin
    queue_req(mk(MODE_LOOKUP, 1'b0, 24'd5, 0));           // empty lookup
    queue_req(mk(MODE_SET, 1'b1, 24'd5, 7));               // empty set
    queue_req(mk(MODE_UNUSED, 1'b0, 24'hFFFFFF, -1));      // unused mode
    queue_req(mk(MODE_APPEND, 1'b0, 24'd0, 32'h7FFFFFFF));
    queue_req(mk(MODE_APPEND, 1'b0, 24'hFFFFFF, 32'h80000000));
    queue_req(mk(MODE_LOOKUP, 1'b0, 24'h800000, 0));
    queue_req(mk(MODE_LOOKUP, 1'b0, 24'hFFFFFF, 0));      // at last point
    queue_req(mk(MODE_SET, 1'b0, 24'h400000, 32'h7FFFFFFF)); // value above last
    queue_req(mk(MODE_SET, 1'b0, 24'h400000, 32'h80000000)); // insert
    queue_req(mk(MODE_SET, 1'b0, 24'h400000, 32'h80000000)); // update
    queue_req(mk(MODE_APPEND, 1'b1, 24'd100, 5));
    queue_req(mk(MODE_APPEND, 1'b1, 24'd50, 9));          // out of order
    queue_req(mk(MODE_LOOKUP, 1'b1, 24'd60, 0));
    queue_req(mk(MODE_LOOKUP, 1'b1, 24'd120, 0));
    queue_req(mk(MODE_SET, 1'b1, 24'd40, 1));              // below first
    queue_req(mk(MODE_SET, 1'b1, 24'd101, 1));             // near match
    queue_req(mk(MODE_SET, 1'b1, 24'd500, 1));             // beyond last
    // fill table 1 to full
    for (int k = 0; k < 31; k++) queue_req(mk(MODE_APPEND, 1'b1, 24'(200 + k), k));
    queue_req(mk(MODE_SET, 1'b1, 24'd99, 3));              // below first, table full
    queue_req(mk(MODE_SET, 1'b1, 24'd200, 3));             // full update
    queue_req(mk(MODE_LOOKUP, 1'b1, 24'd215, 0));
    // random part: random requests mixed with append bursts that add ascending points
    queue_req(mk(MODE_UNUSED, 1'b0, 24'd0, 0));
    while (pending_reqs.size() < 500) begin
      if (pending_reqs.size() % 90 < 12) add_burst(1'($urandom_range(0, 1)));
      else queue_req(rand_req());
    end
  end

  // reset, then end of run
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_rsps.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_rsps = {expected_rsps, calibrate(in_data)};
        if (pending_reqs.size() < 60) quiet <= 1'b1;
      end
      if (in_valid && in_stall) begin
        // hold the request
      end else if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && (in_valid && !in_stall) && $urandom_range(0, 3) == 0) begin
        drv_gap <= $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0)
          report("unexpected response", out_data.result_value, 32'd0);
        else begin
          rsp_t want;
          want = expected_rsps.pop_front();
          if (out_data.result_value !== want.result_value)
            report("result_value", out_data.result_value, want.result_value);
          if (out_data.status !== want.status)
            report("status", 32'(out_data.status), 32'(want.status));
        end
      end
      if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        mon_gap <= $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cal_cnt[0] = 0;
    cal_cnt[1] = 0;
  end
endmodule

[filelist.f]
rtl/plct_pkg.sv
rtl/plct_divider.sv
rtl/piecewise_linear_calibration_table.sv
bench/piecewise_linear_calibration_table_test.sv
